// ----- sv/tsse_pkg.sv -----
// ----------------------------------------------------------------------------
// tsse_pkg: shared types and constants of the seven-segment text encoder
// Holds the character font, the character codes it decodes, the result word
// and the configuration bundle used by the encoder and the result queue.
// ----------------------------------------------------------------------------
package tsse_pkg;

    // Segment bits of one digit, bit 0 at the top segment.
    localparam logic [7:0] SEG_DP = 8'h80;

    // Character codes recognized by the font lookup.
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_CTRL_LO = 8'h01;
    localparam logic [7:0] CHAR_CTRL_HI = 8'h09;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UP_A    = 8'h41;
    localparam logic [7:0] CHAR_UP_Z    = 8'h5A;
    localparam logic [7:0] CHAR_LO_A    = 8'h61;
    localparam logic [7:0] CHAR_LO_Z    = 8'h7A;

    // Depth of the font, and positions in it of the letters and of the entries that follow them.
    localparam int FONT_DEPTH     = 47;
    localparam int FONT_LETTER_IX = 10;
    localparam int FONT_DOT_IX    = 36;
    localparam int FONT_MINUS_IX  = 37;
    localparam int FONT_CTRL_IX   = 38;

    localparam logic [7:0] FONT [0:FONT_DEPTH-1] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7C, 8'h07, 8'h7F, 8'h67,
        8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h30, 8'h1E,
        8'h75, 8'h38, 8'h15, 8'h37, 8'h3F, 8'h73, 8'h6B, 8'h33, 8'h6D, 8'h78,
        8'h3E, 8'h3E, 8'h2A, 8'h76, 8'h6E, 8'h5B,
        8'h80, 8'h40,
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h09, 8'h5D, 8'h5C
    };

    // Configuration register indexes.
    localparam logic [2:0] CFG_ROW_DIGIT0   = 3'd0;
    localparam logic [2:0] CFG_ROW_DIGIT1   = 3'd1;
    localparam logic [2:0] CFG_ROW_DIGIT2   = 3'd2;
    localparam logic [2:0] CFG_SHIFT_DIGIT0 = 3'd3;
    localparam logic [2:0] CFG_SHIFT_DIGIT1 = 3'd4;
    localparam logic [2:0] CFG_SHIFT_DIGIT2 = 3'd5;

    // Depth of the result queue; a power of two.
    localparam int RES_DEPTH = 4;

    typedef struct packed {
        logic [2:0][2:0] row;
        logic [2:0][3:0] shift;
    } cfg_t;

    typedef struct packed {
        logic        digit_valid;
        logic [2:0]  buffer_row;
        logic [15:0] segment_bits;
        logic        last_of_text;
    } result_t;

    // Up to two results produced by one character, res0 first.
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } enc_out_t;

    function automatic logic [7:0] char_pattern(logic [7:0] c);
        logic [7:0] ix;
        logic [7:0] pat;
        ix  = 8'h00;
        pat = 8'h00;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            ix  = c - CHAR_ZERO;
            pat = FONT[ix[5:0]];
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            ix  = c - CHAR_UP_A + 8'(FONT_LETTER_IX);
            pat = FONT[ix[5:0]];
        end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            ix  = c - CHAR_LO_A + 8'(FONT_LETTER_IX);
            pat = FONT[ix[5:0]];
        end else if (c == CHAR_DOT) begin
            pat = FONT[FONT_DOT_IX];
        end else if (c == CHAR_MINUS) begin
            pat = FONT[FONT_MINUS_IX];
        end else if (c >= CHAR_CTRL_LO && c <= CHAR_CTRL_HI) begin
            ix  = c - CHAR_CTRL_LO + 8'(FONT_CTRL_IX);
            pat = FONT[ix[5:0]];
        end
        return pat;
    endfunction

endpackage

// ----- sv/tsse_encoder.sv -----
// ----------------------------------------------------------------------------
// tsse_encoder: character to digit encoder with one-digit lookahead
// Holds the last encoded digit until the next character shows whether a dot
// follows, counts the digits of the string and forms up to two results.
// ----------------------------------------------------------------------------
module tsse_encoder #(
    parameter int DIGITS = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic [7:0]         char_code,
    input  logic               end_of_text,
    input  tsse_pkg::cfg_t     cfg,
    output tsse_pkg::enc_out_t enc_out
);
    import tsse_pkg::*;

    localparam int CW = $clog2(DIGITS + 1);

    logic          held_valid_reg, held_valid_next;
    logic [7:0]    held_pattern_reg, held_pattern_next;
    logic [CW-1:0] digit_count_reg, digit_count_next;

    function automatic result_t make_result(logic valid, logic [7:0] pat, logic last,
                                            logic [CW-1:0] cnt, cfg_t c);
        result_t    r;
        logic [1:0] slot;
        logic [15:0] wide;
        case (cnt)
            CW'(0):  slot = 2'd0;
            CW'(1):  slot = 2'd1;
            default: slot = 2'd2;
        endcase
        wide           = {8'h00, pat} << c.shift[slot];
        r.digit_valid  = valid;
        r.buffer_row   = valid ? c.row[slot] : 3'd0;
        r.segment_bits = valid ? wide : 16'h0000;
        r.last_of_text = last;
        return r;
    endfunction

    always_comb
    begin
        logic          hv_a;
        logic [7:0]    hp_a;
        logic [CW-1:0] cnt_a;
        result_t       bare;

        bare = make_result(1'b0, 8'h00, 1'b1, digit_count_reg, cfg);
        enc_out.count = 2'd0;
        enc_out.res0  = bare;
        enc_out.res1  = bare;
        hv_a  = held_valid_reg;
        hp_a  = held_pattern_reg;
        cnt_a = digit_count_reg;
        held_valid_next   = held_valid_reg;
        held_pattern_next = held_pattern_reg;
        digit_count_next  = digit_count_reg;

        if (item_valid) begin
            if (char_code == CHAR_NUL) begin
                enc_out.count = 2'd1;
                if (held_valid_reg) begin
                    enc_out.res0 = make_result(1'b1, held_pattern_reg, 1'b1,
                                               digit_count_reg, cfg);
                end
                held_valid_next   = 1'b0;
                held_pattern_next = 8'h00;
                digit_count_next  = '0;
            end else begin
                if (char_code == CHAR_DOT && held_valid_reg) begin
                    // A dot after a digit lights that digit's point and releases it.
                    enc_out.res0  = make_result(1'b1, held_pattern_reg | SEG_DP, 1'b0,
                                                digit_count_reg, cfg);
                    enc_out.count = 2'd1;
                    cnt_a = digit_count_reg + 1'b1;
                    hv_a  = 1'b0;
                    hp_a  = 8'h00;
                end else begin
                    if (held_valid_reg) begin
                        enc_out.res0  = make_result(1'b1, held_pattern_reg, 1'b0,
                                                    digit_count_reg, cfg);
                        enc_out.count = 2'd1;
                        cnt_a = digit_count_reg + 1'b1;
                        hv_a  = 1'b0;
                        hp_a  = 8'h00;
                    end
                    if (cnt_a < CW'(DIGITS)) begin
                        hp_a = char_pattern(char_code);
                        hv_a = 1'b1;
                    end
                end

                if (end_of_text) begin
                    if (hv_a) begin
                        if (enc_out.count == 2'd0) begin
                            enc_out.res0 = make_result(1'b1, hp_a, 1'b1, cnt_a, cfg);
                        end else begin
                            enc_out.res1 = make_result(1'b1, hp_a, 1'b1, cnt_a, cfg);
                        end
                        enc_out.count = enc_out.count + 2'd1;
                    end else if (enc_out.count != 2'd0) begin
                        enc_out.res0.last_of_text = 1'b1;
                    end else begin
                        enc_out.count = 2'd1;
                    end
                    held_valid_next   = 1'b0;
                    held_pattern_next = 8'h00;
                    digit_count_next  = '0;
                end else begin
                    held_valid_next   = hv_a;
                    held_pattern_next = hp_a;
                    digit_count_next  = cnt_a;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_valid_reg   <= 1'b0;
            held_pattern_reg <= 8'h00;
            digit_count_reg  <= '0;
        end else begin
            held_valid_reg   <= held_valid_next;
            held_pattern_reg <= held_pattern_next;
            digit_count_reg  <= digit_count_next;
        end
    end

endmodule

// ----- sv/tsse_res_queue.sv -----
// ----------------------------------------------------------------------------
// tsse_res_queue: result queue between encoder and output stream
// Takes up to two results per cycle and hands them out one per transaction.
// ----------------------------------------------------------------------------
module tsse_res_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  tsse_pkg::enc_out_t enc_out,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output tsse_pkg::result_t  out_res
);
    import tsse_pkg::*;

    localparam int PW = $clog2(RES_DEPTH);
    localparam int NW = $clog2(RES_DEPTH + 1);

    result_t       mem [RES_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic [PW-1:0] wr_ptr_inc;
    logic          pop;

    assign wr_ptr_inc = wr_ptr_reg + 1'b1;
    assign out_valid  = (count_reg != '0);
    assign out_res    = mem[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    // Room is judged on the stored level alone, so a two-result character
    // always fits and the input side does not wait on the output handshake.
    assign room       = (count_reg <= NW'(RES_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(enc_out.count);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + NW'(enc_out.count) - NW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (enc_out.count != 2'd0) begin
            mem[wr_ptr_reg] <= enc_out.res0;
        end
        if (enc_out.count == 2'd2) begin
            mem[wr_ptr_inc] <= enc_out.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/text_to_seven_segment_encoder.sv -----
// ----------------------------------------------------------------------------
// text_to_seven_segment_encoder: text stream to seven-segment digit words
// Input register, font encoder with dot lookahead, and a result queue.
// ----------------------------------------------------------------------------
// One character is accepted per cycle. Each character is registered in the
// input register, then encoded against the font and the held digit, and its
// results enter a four-entry queue that feeds the output stream. A character
// yields zero, one or two results, but two results only come from a character
// that ends a string, and the character after it yields at most one, so with
// the output always ready the queue never holds more than two results and one
// character is taken every cycle. Output stalls fill the queue, which takes a
// character only while it holds two results or fewer. A digit is held until
// the next character, so a string's digits come out one character late;
// end_of_text or code 0 flushes the held digit and marks the final result
// with tlast. Configuration must be written only while no transaction is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module text_to_seven_segment_encoder #(
    parameter int DIGITS = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_of_text
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] buffer_row, [18:3] segment_bits, rest zero
    output logic        m_tuser,   // [0] digit_valid
    output logic        m_tlast,   // last_of_text
    // Configuration writes.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [3:0]  cfg_wdata
);
    import tsse_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_eot_reg;
    logic       advance;
    logic       room;

    logic [2:0] row_digit0_reg, row_digit1_reg, row_digit2_reg;
    logic [3:0] shift_digit0_reg, shift_digit1_reg, shift_digit2_reg;
    cfg_t       cfg;
    enc_out_t   enc_out;
    result_t    out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            row_digit0_reg   <= 3'd0;
            row_digit1_reg   <= 3'd1;
            row_digit2_reg   <= 3'd3;
            shift_digit0_reg <= 4'd0;
            shift_digit1_reg <= 4'd0;
            shift_digit2_reg <= 4'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ROW_DIGIT0:   row_digit0_reg   <= cfg_wdata[2:0];
                CFG_ROW_DIGIT1:   row_digit1_reg   <= cfg_wdata[2:0];
                CFG_ROW_DIGIT2:   row_digit2_reg   <= cfg_wdata[2:0];
                CFG_SHIFT_DIGIT0: shift_digit0_reg <= cfg_wdata;
                CFG_SHIFT_DIGIT1: shift_digit1_reg <= cfg_wdata;
                CFG_SHIFT_DIGIT2: shift_digit2_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.row[0]   = row_digit0_reg;
        cfg.row[1]   = row_digit1_reg;
        cfg.row[2]   = row_digit2_reg;
        cfg.shift[0] = shift_digit0_reg;
        cfg.shift[1] = shift_digit1_reg;
        cfg.shift[2] = shift_digit2_reg;
    end

    // The input register moves on whenever the queue has room for two results.
    assign advance  = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
    end

    tsse_encoder #(
        .DIGITS (DIGITS)
    ) u_encoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (advance),
        .char_code   (in_char_reg),
        .end_of_text (in_eot_reg),
        .cfg         (cfg),
        .enc_out     (enc_out)
    );

    tsse_res_queue u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .enc_out   (enc_out),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {5'b00000, out_res.segment_bits, out_res.buffer_row};
    assign m_tuser = out_res.digit_valid;
    assign m_tlast = out_res.last_of_text;

    // Results are only produced for a character leaving the input register.
    a_push_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        (enc_out.count != 2'd0) |-> advance)
        else $error("result pushed without a character");

    // A result without a digit is always the bare end of a string.
    a_bare_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (enc_out.count != 2'd0 && !enc_out.res0.digit_valid) |->
            (enc_out.res0.last_of_text && enc_out.count == 2'd1))
        else $error("blank result that does not end the string");

    // Two results come only from a flush: the first is open, the second ends it.
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (enc_out.count == 2'd2) |->
            (enc_out.res0.digit_valid && !enc_out.res0.last_of_text &&
             enc_out.res1.digit_valid && enc_out.res1.last_of_text))
        else $error("bad result pair");

    // A queue without room keeps a waiting character in the input register.
    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !room) |=> in_valid_reg)
        else $error("character dropped while the queue was full");

endmodule
